// File: rtl/core/pts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Process table scheduler package
// Table size, slot state codes, policy, event and config codes, slot record
// layout and the control state encoding used by the scheduler module.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // Ratio operands: numerator is run ticks times decay, denominator the tick sum.
    localparam int NUM_W  = 36;
    localparam int DEN_W  = 34;
    localparam int HALF_W = DEN_W / 2;
    localparam int PRD_W  = NUM_W + HALF_W;
    localparam int CMP_W  = NUM_W + DEN_W;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_RUNNABLE = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [1:0] POL_RR    = 2'd0;
    localparam logic [1:0] POL_ACC   = 2'd1;
    localparam logic [1:0] POL_RATIO = 2'd2;

    localparam logic [1:0] NXT_RUNNABLE = 2'd0;
    localparam logic [1:0] NXT_SLEEPING = 2'd1;
    localparam logic [1:0] NXT_ZOMBIE   = 2'd2;
    localparam logic [1:0] NXT_NONE     = 2'd3;

    localparam logic [1:0] CFG_POLICY   = 2'd0;
    localparam logic [1:0] CFG_PRIORITY = 2'd1;

    localparam logic [3:0] PRIO_RESET = 4'd5;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_PICK   = 3'd1,
        MODE_RETURN = 3'd2,
        MODE_ALLOC  = 3'd3,
        MODE_WAKE   = 3'd4,
        MODE_FREE   = 3'd5,
        MODE_SETPRI = 3'd6
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_M1,
        S_M2,
        S_CMP,
        S_FRD,
        S_FWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  st;
        logic [63:0] acc;
        logic [3:0]  prio;
        logic [3:0]  decay;
        logic [31:0] run;
        logic [31:0] ready;
        logic [31:0] sleep;
        logic [31:0] chan;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(NUM_SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/pts_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler event channel
// Valid/ready channel carrying one scheduling event request.
// ----------------------------------------------------------------------------
interface pts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [5:0]  slot;
    logic [1:0]  next_state;
    logic [31:0] channel;
    logic [3:0]  priority_req;
    logic [3:0]  decay;

    modport source (output valid, mode, slot, next_state, channel, priority_req, decay,
                    input ready);
    modport sink   (input valid, mode, slot, next_state, channel, priority_req, decay,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/core/pts_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Scheduler result channel
// Valid/ready channel carrying the outcome of one scheduling event.
// ----------------------------------------------------------------------------
interface pts_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] chosen_slot;
    logic [6:0] woken_count;

    modport source (output valid, found, chosen_slot, woken_count, input ready);
    modport sink   (input valid, found, chosen_slot, woken_count, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pts_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/process_table_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Process table scheduler
// Task slot table held in one RAM; events are handled by read-modify-write
// sweeps over the table under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Content
//  i_req     in         valid/ready    mode, slot, next_state, channel, ...
//  o_rsp     out        valid/ready    found, chosen_slot, woken_count
//  i_cfg_*   in         write enable   sched_policy, default_priority
//
//  Each table entry is read from the RAM, then modified and written back;
//  tick, pick, allocate and wake sweep the table this way, and wake takes a
//  second sweep when anything woke. Lowest-ratio pick adds the split multiply
//  steps M1 and M2 and a compare step per compared entry. Single-slot events
//  read the slot, then write it back. Reset clears the per-slot valid bits at
//  once, so the block is ready straight after reset. Requests are taken only
//  while idle; a held result does not block the next request from starting.
// ----------------------------------------------------------------------------
module process_table_scheduler
    import pts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [3:0] i_cfg_data,
    pts_req_if.sink         i_req,
    pts_rsp_if.source       o_rsp
);
    t_state r_state, n_state;

    logic [1:0] r_policy;
    logic [3:0] r_def_prio;

    t_mode             r_mode;
    logic [1:0]        r_nxt;
    logic [31:0]       r_chan;
    logic [3:0]        r_preq;
    logic [3:0]        r_dec;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_best, n_best;
    logic              r_has, n_has;
    logic              r_defined, n_defined;
    logic [NUM_W-1:0]  r_bnum, n_bnum;
    logic [DEN_W-1:0]  r_bden, n_bden;
    logic [NUM_W-1:0]  r_cnum, n_cnum;
    logic [DEN_W-1:0]  r_cden, n_cden;
    logic [PRD_W-1:0]  r_pl, r_ql, r_ph, r_qh;
    logic [63:0]       r_min, n_min;
    logic              r_min_has, n_min_has;
    logic              r_any_active, n_any_active;
    logic [CNT_W-1:0]  r_woken, n_woken;
    logic              r_pass, n_pass;
    logic [IDX_W-1:0]  r_rr, n_rr;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_mark, n_mark;

    logic       r_out_valid;
    logic       r_out_found;
    logic [5:0] r_out_chosen;
    logic [6:0] r_out_woken;
    logic       r_found, n_found;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_wdata, ram_rdata;
    t_rec             rec, wrec;

    logic             req_acc, in_table, out_free;
    logic             scan_last, runnable, active, sleep_hit;
    logic [DEN_W-1:0] ex_den;
    logic [NUM_W-1:0] ex_num;
    logic             ex_take, ex_wake, go_mul, rr_hit, has_now, stop;
    logic [CNT_W-1:0] woken_now;
    logic [CMP_W-1:0] lhs, rhs;
    logic             ratio_less;
    logic [64:0]      acc_sum;

    pts_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign in_table    = (int'(i_req.slot) < NUM_SLOTS);
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.chosen_slot = r_out_chosen;
    assign o_rsp.woken_count = r_out_woken;

    // An entry that has never been allocated, or has been freed, reads as all zero.
    assign rec = r_valid[r_idx] ? t_rec'(ram_rdata) : '0;

    assign scan_last = (r_cnt == CNT_W'(NUM_SLOTS - 1));
    assign runnable  = (rec.st == ST_RUNNABLE);
    assign active    = (rec.st == ST_RUNNABLE) || (rec.st == ST_RUNNING);
    assign sleep_hit = !r_pass && (rec.st == ST_SLEEPING) && (rec.chan == r_chan);
    assign ex_den    = DEN_W'(rec.run) + DEN_W'(rec.ready) + DEN_W'(rec.sleep);
    assign ex_num    = NUM_W'(rec.run) * NUM_W'(rec.decay);
    assign acc_sum   = {1'b0, rec.acc} + 65'(rec.prio);

    assign lhs        = CMP_W'(r_pl) + (CMP_W'(r_ph) << HALF_W);
    assign rhs        = CMP_W'(r_ql) + (CMP_W'(r_qh) << HALF_W);
    assign ratio_less = (lhs < rhs);

    always_comb begin
        ex_take = 1'b0;
        go_mul  = 1'b0;
        rr_hit  = 1'b0;
        ex_wake = 1'b0;
        if (r_state == S_EX) begin
            case (r_mode)
                MODE_PICK: begin
                    if (runnable) begin
                        case (r_policy)
                            POL_RR: begin
                                ex_take = 1'b1;
                                rr_hit  = 1'b1;
                            end
                            POL_ACC: ex_take = !r_has || (rec.acc < r_min);
                            POL_RATIO: begin
                                if (ex_den == '0) begin
                                    ex_take = !r_has;
                                end else if (!r_has || !r_defined) begin
                                    ex_take = 1'b1;
                                end else begin
                                    go_mul = 1'b1;
                                end
                            end
                            default: ex_take = 1'b0;
                        endcase
                    end
                end
                MODE_ALLOC: ex_take = (rec.st == ST_UNUSED) && !r_has;
                MODE_WAKE:  ex_wake = sleep_hit;
                default:    ex_take = 1'b0;
            endcase
        end
    end

    assign has_now   = r_has || ex_take;
    assign woken_now = r_woken + CNT_W'(ex_wake);
    assign stop      = scan_last || rr_hit;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    case (t_mode'(i_req.mode))
                        MODE_TICK, MODE_ALLOC, MODE_WAKE: n_state = S_RD;
                        MODE_PICK: n_state = (r_policy == 2'd3) ? S_DONE : S_RD;
                        MODE_RETURN, MODE_FREE, MODE_SETPRI:
                            n_state = in_table ? S_FRD : S_DONE;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RD: n_state = S_EX;
            S_EX, S_CMP: begin
                if (go_mul) begin
                    n_state = S_M1;
                end else if (!stop) begin
                    n_state = S_RD;
                end else begin
                    case (r_mode)
                        MODE_PICK:  n_state = has_now ? S_FRD : S_DONE;
                        MODE_ALLOC: n_state = has_now ? S_FWR : S_DONE;
                        MODE_WAKE:  n_state = (!r_pass && woken_now != '0) ? S_RD : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_CMP;
            S_FRD:  n_state = S_FWR;
            S_FWR:  n_state = S_DONE;
            S_DONE: n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_best       = r_best;
        n_has        = r_has;
        n_defined    = r_defined;
        n_bnum       = r_bnum;
        n_bden       = r_bden;
        n_cnum       = r_cnum;
        n_cden       = r_cden;
        n_min        = r_min;
        n_min_has    = r_min_has;
        n_any_active = r_any_active;
        n_woken      = r_woken;
        n_pass       = r_pass;
        n_rr         = r_rr;
        n_valid      = r_valid;
        n_mark       = r_mark;
        n_found      = r_found;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;
        wrec         = rec;

        unique case (r_state)
            S_IDLE: begin
                n_cnt        = '0;
                n_has        = 1'b0;
                n_defined    = 1'b0;
                n_min_has    = 1'b0;
                n_any_active = 1'b0;
                n_woken      = '0;
                n_pass       = 1'b0;
                n_mark       = '0;
                n_found      = 1'b0;
                n_best       = '0;
                if (t_mode'(i_req.mode) == MODE_PICK && r_policy == POL_RR) begin
                    n_idx = r_rr;
                end else if (t_mode'(i_req.mode) == MODE_RETURN ||
                             t_mode'(i_req.mode) == MODE_FREE ||
                             t_mode'(i_req.mode) == MODE_SETPRI) begin
                    n_idx = IDX_W'(i_req.slot);
                end else begin
                    n_idx = '0;
                end
            end
            S_RD, S_FRD: ram_re = 1'b1;
            S_EX, S_CMP: begin
                if (r_state == S_CMP) begin
                    if (ratio_less) begin
                        n_best = r_idx;
                        n_bnum = r_cnum;
                        n_bden = r_cden;
                    end
                end else begin
                    case (r_mode)
                        MODE_TICK: begin
                            case (rec.st)
                                ST_RUNNING:  wrec.run   = sat_inc(rec.run);
                                ST_RUNNABLE: wrec.ready = sat_inc(rec.ready);
                                ST_SLEEPING: wrec.sleep = sat_inc(rec.sleep);
                                default:     wrec = rec;
                            endcase
                            ram_we = r_valid[r_idx];
                        end
                        MODE_PICK: begin
                            if (ex_take) begin
                                n_best    = r_idx;
                                n_has     = 1'b1;
                                n_min     = rec.acc;
                                if (ex_den != '0) begin
                                    n_defined = 1'b1;
                                    n_bnum    = ex_num;
                                    n_bden    = ex_den;
                                end
                            end
                            n_cnum = ex_num;
                            n_cden = ex_den;
                        end
                        MODE_ALLOC: begin
                            if (ex_take) begin
                                n_best = r_idx;
                                n_has  = 1'b1;
                            end
                            if (active && (!r_min_has || rec.acc < r_min)) begin
                                n_min     = rec.acc;
                                n_min_has = 1'b1;
                            end
                        end
                        MODE_WAKE: begin
                            if (!r_pass) begin
                                if (active) begin
                                    n_any_active = 1'b1;
                                end
                                if ((active || sleep_hit) && (!r_min_has || rec.acc < r_min)) begin
                                    n_min     = rec.acc;
                                    n_min_has = 1'b1;
                                end
                                if (sleep_hit) begin
                                    wrec.st         = ST_RUNNABLE;
                                    ram_we          = 1'b1;
                                    n_mark[r_idx]   = 1'b1;
                                    n_woken         = woken_now;
                                end
                            end else if (r_mark[r_idx]) begin
                                // A lone waker into an empty run queue restarts from zero.
                                wrec.acc = (r_woken == CNT_W'(1) && !r_any_active) ? '0 : r_min;
                                ram_we   = 1'b1;
                            end
                        end
                        default: wrec = rec;
                    endcase
                end

                if (!go_mul) begin
                    if (!stop) begin
                        n_idx = idx_inc(r_idx);
                        n_cnt = r_cnt + 1'b1;
                    end else if (r_mode == MODE_WAKE && !r_pass) begin
                        n_pass = 1'b1;
                        n_idx  = '0;
                        n_cnt  = '0;
                    end else if (r_mode == MODE_PICK || r_mode == MODE_ALLOC) begin
                        // The winner includes an entry taken on this very cycle.
                        n_idx = n_best;
                    end
                end
            end
            S_FWR: begin
                case (r_mode)
                    MODE_PICK: begin
                        wrec.st   = ST_RUNNING;
                        wrec.chan = '0;
                        ram_we    = 1'b1;
                        n_found   = 1'b1;
                        if (r_policy == POL_RR) begin
                            n_rr = idx_inc(r_idx);
                        end
                    end
                    MODE_RETURN: begin
                        if (r_valid[r_idx] && rec.st == ST_RUNNING && r_nxt != NXT_NONE) begin
                            wrec.acc = acc_sum[64] ? '1 : acc_sum[63:0];
                            case (r_nxt)
                                NXT_RUNNABLE: wrec.st = ST_RUNNABLE;
                                NXT_SLEEPING: begin
                                    wrec.st   = ST_SLEEPING;
                                    wrec.chan = r_chan;
                                end
                                default: wrec.st = ST_ZOMBIE;
                            endcase
                            ram_we = 1'b1;
                        end
                    end
                    MODE_ALLOC: begin
                        wrec.st    = ST_RUNNABLE;
                        wrec.acc   = r_min_has ? r_min : '0;
                        wrec.prio  = r_def_prio;
                        wrec.decay = r_dec;
                        wrec.run   = '0;
                        wrec.ready = '0;
                        wrec.sleep = '0;
                        wrec.chan  = '0;
                        ram_we     = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_found    = 1'b1;
                    end
                    MODE_FREE: begin
                        // A freed slot reads back as all zero through its valid bit.
                        if (rec.st == ST_ZOMBIE) begin
                            n_valid[r_idx] = 1'b0;
                        end
                    end
                    MODE_SETPRI: begin
                        if (rec.st != ST_UNUSED) begin
                            wrec.prio = r_preq;
                            ram_we    = 1'b1;
                        end
                    end
                    default: wrec = rec;
                endcase
            end
            default: wrec = rec;
        endcase
        ram_wdata = REC_W'(wrec);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_policy    <= POL_RR;
            r_def_prio  <= PRIO_RESET;
            r_rr        <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rr    <= n_rr;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:   r_policy   <= i_cfg_data[1:0];
                    CFG_PRIORITY: r_def_prio <= i_cfg_data;
                    default:      r_policy   <= r_policy;
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_mode              <= t_mode'(i_req.mode);
            r_nxt               <= i_req.next_state;
            r_chan              <= i_req.channel;
            r_preq              <= i_req.priority_req;
            r_dec               <= i_req.decay;
        end
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_best       <= n_best;
        r_has        <= n_has;
        r_defined    <= n_defined;
        r_bnum       <= n_bnum;
        r_bden       <= n_bden;
        r_cnum       <= n_cnum;
        r_cden       <= n_cden;
        r_min        <= n_min;
        r_min_has    <= n_min_has;
        r_any_active <= n_any_active;
        r_woken      <= n_woken;
        r_pass       <= n_pass;
        r_mark       <= n_mark;
        r_found      <= n_found;
        if (r_state == S_M1) begin
            r_pl <= r_cnum * PRD_W'(r_bden[HALF_W-1:0]);
            r_ql <= r_bnum * PRD_W'(r_cden[HALF_W-1:0]);
        end
        if (r_state == S_M2) begin
            r_ph <= r_cnum * PRD_W'(r_bden[DEN_W-1:HALF_W]);
            r_qh <= r_bnum * PRD_W'(r_cden[DEN_W-1:HALF_W]);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_found  <= r_found;
            r_out_chosen <= r_found ? 6'(r_idx) : 6'd0;
            r_out_woken  <= (r_mode == MODE_WAKE) ? 7'(r_woken) : 7'd0;
        end
    end

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_EX || r_state == S_FWR))
        else $error("table written outside a write cycle");

    a_alloc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FWR && r_mode == MODE_ALLOC) |=> r_valid[$past(r_idx)])
        else $error("allocated slot not marked valid");

    a_woken_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (int'(r_woken) <= NUM_SLOTS))
        else $error("woken count exceeds table size");

    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_M2 && r_mode == MODE_PICK))
        else $error("ratio compare without multiply");

endmodule
`default_nettype wire
